[hw/rtl/stg_pkg.sv]
// Shared types and constants for the trapezoidal stepper step generator.
package stg_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_SETPOS = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_BAD_RAMP = 2'd2
  } status_t;

  localparam logic [1:0] CFG_START_PERIOD    = 2'd0;
  localparam logic [1:0] CFG_MIN_PERIOD      = 2'd1;
  localparam logic [1:0] CFG_ACCEL_COUNT     = 2'd2;
  localparam logic [1:0] CFG_PULSE_HIGH_TIME = 2'd3;

  localparam int unsigned CFG_IDX_W = 32;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] RST_START_PERIOD    = 16'd500;
  localparam logic [15:0] RST_MIN_PERIOD      = 16'd100;
  localparam logic [7:0]  RST_ACCEL_COUNT     = 8'd1;
  localparam logic [7:0]  RST_PULSE_HIGH_TIME = 8'd2;
  localparam logic [23:0] RST_RAMP            = 24'd401;

  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [7:0]  RAMP_CNT_MAX = 8'hFF;

endpackage

[hw/rtl/stepper_trapezoid_step_generator.sv]
// Top level of the single-axis trapezoidal stepper step generator.
// An accepted input transaction's result is registered and offered in the next cycle.
// Throughput: one transaction per cycle with out_ready high; any action is one register pass.
// The output register frees while it is taken, so input stays ready under a steady drain.
// The ramp length is recomputed when a ramp register is written, ready for the next move.
// Reset (synchronous, rst_n low) clears all motion state and loads the default registers.
module stepper_trapezoid_step_generator
  import stg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic signed [31:0]   in_target_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_step_out,
  output logic                 out_dir_out,
  output logic                 out_enable_out,
  output logic                 out_moving,
  output logic signed [31:0]   out_position,
  output logic [1:0]           out_status
);

  logic [15:0] start_period_r, start_period_nxt;
  logic [15:0] min_period_r, min_period_nxt;
  logic [7:0]  accel_count_r, accel_count_nxt;
  logic [7:0]  pulse_high_r, pulse_high_nxt;
  logic [23:0] ramp_r, ramp_nxt;
  logic [7:0]  eff_nxt;
  logic [15:0] diff_nxt;

  always_comb begin
    start_period_nxt = start_period_r;
    min_period_nxt   = min_period_r;
    accel_count_nxt  = accel_count_r;
    pulse_high_nxt   = pulse_high_r;
    if (cfg_wr_en) begin
      if (cfg_index == CFG_IDX_W'(CFG_START_PERIOD)) start_period_nxt = cfg_wdata;
      if (cfg_index == CFG_IDX_W'(CFG_MIN_PERIOD)) min_period_nxt = cfg_wdata;
      if (cfg_index == CFG_IDX_W'(CFG_ACCEL_COUNT)) accel_count_nxt = cfg_wdata[7:0];
      if (cfg_index == CFG_IDX_W'(CFG_PULSE_HIGH_TIME)) pulse_high_nxt = cfg_wdata[7:0];
    end
    eff_nxt  = (accel_count_nxt == 8'd0) ? 8'd1 : accel_count_nxt;
    diff_nxt = start_period_nxt - min_period_nxt;
    ramp_nxt = 24'(diff_nxt * eff_nxt) + 24'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_period_r <= RST_START_PERIOD;
      min_period_r   <= RST_MIN_PERIOD;
      accel_count_r  <= RST_ACCEL_COUNT;
      pulse_high_r   <= RST_PULSE_HIGH_TIME;
      ramp_r         <= RST_RAMP;
    end else if (cfg_wr_en) begin
      start_period_r <= start_period_nxt;
      min_period_r   <= min_period_nxt;
      accel_count_r  <= accel_count_nxt;
      pulse_high_r   <= pulse_high_nxt;
      ramp_r         <= ramp_nxt;
    end
  end

  logic [31:0] position_r, position_nxt;
  logic [31:0] target_r, target_nxt;
  logic [31:0] accel_end_r, accel_end_nxt;
  logic [31:0] decel_start_r, decel_start_nxt;
  logic [31:0] last_high_r, last_high_nxt;
  logic [31:0] next_high_r, next_high_nxt;
  logic [31:0] next_low_r, next_low_nxt;
  logic [31:0] clock_us_r, clock_us_nxt;
  logic [15:0] period_r, period_nxt;
  logic [7:0]  ramp_cnt_r, ramp_cnt_nxt;
  logic        reverse_r, reverse_nxt;
  logic        step_high_r, step_high_nxt;
  logic        active_r, active_nxt;
  status_t     status_nxt;

  logic        out_valid_r;
  logic        step_out_r, dir_out_r, enable_out_r, moving_r;
  logic [31:0] position_out_r;
  status_t     status_r;

  logic        accept;
  logic [7:0]  eff_accel;
  logic [31:0] tgt_u;
  logic        rev_mv;
  logic [31:0] steps;
  logic [31:0] half;
  logic [31:0] span;
  logic        span_short;
  logic [31:0] pos_step;
  logic        fall;
  logic        ramp_up;
  logic        ramp_down;
  logic [7:0]  cnt_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign eff_accel = (accel_count_r == 8'd0) ? 8'd1 : accel_count_r;
  assign tgt_u     = in_target_position;

  always_comb begin
    position_nxt    = position_r;
    target_nxt      = target_r;
    accel_end_nxt   = accel_end_r;
    decel_start_nxt = decel_start_r;
    last_high_nxt   = last_high_r;
    next_high_nxt   = next_high_r;
    next_low_nxt    = next_low_r;
    clock_us_nxt    = clock_us_r;
    period_nxt      = period_r;
    ramp_cnt_nxt    = ramp_cnt_r;
    reverse_nxt     = reverse_r;
    step_high_nxt   = step_high_r;
    active_nxt      = active_r;
    status_nxt      = ST_OK;

    rev_mv     = $signed(tgt_u) < $signed(position_r);
    steps      = rev_mv ? (position_r - tgt_u) : (tgt_u - position_r);
    half       = {1'b0, steps[31:1]};
    span_short = steps < {7'd0, ramp_r, 1'b0};
    span       = span_short ? half : {8'd0, ramp_r};

    pos_step  = reverse_r ? (position_r - 32'd1) : (position_r + 32'd1);
    fall      = 1'b0;
    ramp_up   = 1'b0;
    ramp_down = 1'b0;
    cnt_inc   = (ramp_cnt_r < RAMP_CNT_MAX) ? (ramp_cnt_r + 8'd1) : ramp_cnt_r;

    unique case (in_action)
      ACT_TICK: begin
        clock_us_nxt = clock_us_r + 32'd1;
        if (active_r) begin
          if (position_r == target_r) begin
            active_nxt    = 1'b0;
            step_high_nxt = 1'b0;
          end else begin
            fall = step_high_r && (next_low_r <= clock_us_nxt);
            if (fall) begin
              step_high_nxt = 1'b0;
              position_nxt  = pos_step;
              ramp_cnt_nxt  = cnt_inc;
              if (!reverse_r) begin
                ramp_up   = $signed(pos_step) < $signed(accel_end_r);
                ramp_down = !ramp_up && ($signed(decel_start_r) < $signed(pos_step));
              end else begin
                ramp_up   = $signed(accel_end_r) < $signed(pos_step);
                ramp_down = !ramp_up && ($signed(pos_step) < $signed(decel_start_r));
              end
              if ((ramp_up || ramp_down) && (cnt_inc >= eff_accel)) begin
                ramp_cnt_nxt = 8'd0;
                if (ramp_up) begin
                  if (period_r > min_period_r) period_nxt = period_r - 16'd1;
                end else begin
                  if (period_r < PERIOD_MAX) period_nxt = period_r + 16'd1;
                end
              end
              next_high_nxt = last_high_r + {16'd0, period_nxt};
              next_low_nxt  = next_high_nxt + {24'd0, pulse_high_r};
            end
            if (!step_high_nxt && (position_nxt != target_r) &&
                (next_high_nxt <= clock_us_nxt)) begin
              step_high_nxt = 1'b1;
              last_high_nxt = clock_us_nxt;
            end
          end
        end
      end
      ACT_MOVE: begin
        if (active_r) begin
          status_nxt = ST_BUSY;
        end else if (tgt_u == position_r) begin
          target_nxt = tgt_u;
        end else if (start_period_r < min_period_r) begin
          status_nxt = ST_BAD_RAMP;
        end else begin
          if (!rev_mv) begin
            accel_end_nxt   = position_r + span;
            decel_start_nxt = span_short ? (tgt_u - span + 32'd1) : (tgt_u - span);
          end else begin
            accel_end_nxt   = position_r - span;
            decel_start_nxt = span_short ? (tgt_u + span - 32'd1) : (tgt_u + span);
          end
          target_nxt    = tgt_u;
          reverse_nxt   = rev_mv;
          period_nxt    = start_period_r;
          ramp_cnt_nxt  = 8'd0;
          next_high_nxt = 32'd0;
          next_low_nxt  = {24'd0, pulse_high_r};
          last_high_nxt = 32'd0;
          step_high_nxt = 1'b0;
          clock_us_nxt  = 32'd0;
          active_nxt    = 1'b1;
        end
      end
      ACT_SETPOS: begin
        if (active_r) begin
          status_nxt = ST_BUSY;
        end else begin
          position_nxt = tgt_u;
          target_nxt   = tgt_u;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r    <= '0;
      target_r      <= '0;
      accel_end_r   <= '0;
      decel_start_r <= '0;
      last_high_r   <= '0;
      next_high_r   <= '0;
      next_low_r    <= '0;
      clock_us_r    <= '0;
      period_r      <= '0;
      ramp_cnt_r    <= '0;
      reverse_r     <= 1'b0;
      step_high_r   <= 1'b0;
      active_r      <= 1'b0;
    end else if (accept) begin
      position_r    <= position_nxt;
      target_r      <= target_nxt;
      accel_end_r   <= accel_end_nxt;
      decel_start_r <= decel_start_nxt;
      last_high_r   <= last_high_nxt;
      next_high_r   <= next_high_nxt;
      next_low_r    <= next_low_nxt;
      clock_us_r    <= clock_us_nxt;
      period_r      <= period_nxt;
      ramp_cnt_r    <= ramp_cnt_nxt;
      reverse_r     <= reverse_nxt;
      step_high_r   <= step_high_nxt;
      active_r      <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_out_r     <= step_high_nxt;
      dir_out_r      <= reverse_nxt;
      enable_out_r   <= active_nxt;
      moving_r       <= position_nxt != target_nxt;
      position_out_r <= position_nxt;
      status_r       <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_out   = step_out_r;
  assign out_dir_out    = dir_out_r;
  assign out_enable_out = enable_out_r;
  assign out_moving     = moving_r;
  assign out_position   = position_out_r;
  assign out_status     = status_r;

  a_step_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    step_high_r |-> active_r)
    else $error("step output high without an active move");

  a_busy_move: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_MOVE) && active_r |=> (out_status == ST_BUSY) && out_valid)
    else $error("move during an active move not rejected as busy");

  a_tick_clock: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_TICK) |=> clock_us_r == $past(clock_us_r) + 32'd1)
    else $error("tick did not advance the microsecond clock");

  a_move_ends: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_TICK) && active_r && (position_r == target_r)
    |=> !active_r && !out_enable_out)
    else $error("move did not end on the tick after reaching the target");

endmodule
